FILE: hdl/assert_macros.svh
// Assertion macros shared by the line rasterizer RTL.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that prop holds at every clock edge outside reset.
`define LRAST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that expr never holds at a clock edge outside reset.
`define LRAST_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define LRAST_ASSERT(lbl, prop, msg)
`define LRAST_NEVER(lbl, expr, msg)
`endif
`endif

FILE: hdl/lrast_pkg.sv
// Shared types and constants for the line rasterizer.
// Used by lrast_ctrl, lrast_dp and line_rasterizer_all_octants.
package lrast_pkg;

  // Width of every coordinate port.
  localparam int unsigned PixW = 6;
  // Default tile size, as log2 of pixels per side.
  localparam int unsigned CoordBitsDef = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } lrast_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;   // capture a new request
    logic setup;  // derive deltas, length and decision term
    logic step;   // advance to the next pixel
  } lrast_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic last;   // current pixel is the end point
  } lrast_sts_t;

endpackage

FILE: hdl/lrast_dp.sv
// Datapath of the line rasterizer: coordinates, decision term, pixel count.
// Depends on lrast_pkg; driven by commands from lrast_ctrl.
module lrast_dp #(
  parameter int unsigned COORD_BITS = lrast_pkg::CoordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lrast_pkg::lrast_cmd_t      cmd_i,
  output lrast_pkg::lrast_sts_t      sts_o,
  input  logic [lrast_pkg::PixW-1:0] x_start_i,
  input  logic [lrast_pkg::PixW-1:0] y_start_i,
  input  logic [lrast_pkg::PixW-1:0] x_end_i,
  input  logic [lrast_pkg::PixW-1:0] y_end_i,
  output logic [lrast_pkg::PixW-1:0] pixel_x_o,
  output logic [lrast_pkg::PixW-1:0] pixel_y_o
);
  import lrast_pkg::*;

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + 3;

  logic [CW-1:0] x_q, x_d, y_q, y_d;
  logic [CW-1:0] xe_q, ye_q;
  logic [CW-1:0] rem_q, rem_d;
  logic [DW-1:0] d_q, d_d;
  logic [DW-1:0] inc_step_q, inc_step_d;
  logic [DW-1:0] inc_stay_q, inc_stay_d;
  logic          x_major_q, x_major_d;
  logic          x_neg_q, x_neg_d;
  logic          y_neg_q, y_neg_d;

  logic [CW:0]   dx, dy;
  logic [CW-1:0] adx, ady, len, minor, diff;
  logic          minor_step;
  logic          step_x, step_y;

  // Setup: deltas and magnitudes from the captured endpoints.
  always_comb begin
    dx    = {1'b0, xe_q} - {1'b0, x_q};
    dy    = {1'b0, ye_q} - {1'b0, y_q};
    adx   = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady   = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    x_major_d = adx > ady;
    len   = x_major_d ? adx : ady;
    minor = x_major_d ? ady : adx;
    diff  = len - minor;
    x_neg_d    = dx[CW];
    y_neg_d    = dy[CW];
    inc_step_d = {2'b00, diff, 1'b0};
    inc_stay_d = {2'b00, minor, 1'b0};
  end

  // Step: minor axis moves when the decision term is not positive.
  always_comb begin
    minor_step = d_q[DW-1] || (d_q == '0);
    step_x     = x_major_q || minor_step;
    step_y     = !x_major_q || minor_step;
    x_d   = x_neg_q ? x_q - CW'(1) : x_q + CW'(1);
    y_d   = y_neg_q ? y_q - CW'(1) : y_q + CW'(1);
    d_d   = minor_step ? d_q + inc_step_q : d_q - inc_stay_q;
    rem_d = rem_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q        <= '0;
      y_q        <= '0;
      xe_q       <= '0;
      ye_q       <= '0;
      x_major_q  <= 1'b0;
      x_neg_q    <= 1'b0;
      y_neg_q    <= 1'b0;
      inc_step_q <= '0;
      inc_stay_q <= '0;
      d_q        <= '0;
      rem_q      <= '0;
    end else if (cmd_i.load) begin
      x_q  <= x_start_i[CW-1:0];
      y_q  <= y_start_i[CW-1:0];
      xe_q <= x_end_i[CW-1:0];
      ye_q <= y_end_i[CW-1:0];
    end else if (cmd_i.setup) begin
      x_major_q  <= x_major_d;
      x_neg_q    <= x_neg_d;
      y_neg_q    <= y_neg_d;
      inc_step_q <= inc_step_d;
      inc_stay_q <= inc_stay_d;
      d_q        <= {3'b000, len} - {2'b00, minor, 1'b0};
      rem_q      <= len;
    end else if (cmd_i.step) begin
      if (step_x) x_q <= x_d;
      if (step_y) y_q <= y_d;
      d_q   <= d_d;
      rem_q <= rem_d;
    end
  end

  assign sts_o.last = (rem_q == '0);
  assign pixel_x_o  = PixW'(x_q);
  assign pixel_y_o  = PixW'(y_q);

endmodule

FILE: hdl/lrast_ctrl.sv
// Controller of the line rasterizer: sequences capture, setup and emission.
// Depends on lrast_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lrast_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  lrast_pkg::lrast_sts_t sts_i,
  output lrast_pkg::lrast_cmd_t cmd_o
);
  import lrast_pkg::*;

  lrast_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `LRAST_ASSERT(a_setup_to_emit, state_q == ST_SETUP |=> state_q == ST_EMIT, "no emit after setup")
  `LRAST_ASSERT(a_stall_holds, out_valid_o && out_stall_i |=> out_valid_o && $stable(sts_i), "pixel lost")
  `LRAST_ASSERT(a_last_ends, out_valid_o && !out_stall_i && sts_i.last |=> state_q == ST_IDLE, "overran")
  `LRAST_NEVER(a_step_past_last, cmd_o.step && sts_i.last, "step beyond end point")
  `LRAST_NEVER(a_load_busy, cmd_o.load && state_q != ST_IDLE, "request captured while busy")

endmodule

FILE: hdl/line_rasterizer_all_octants.sv
// Midpoint line rasterizer for all eight octants: one request in, its pixels out.
// Depends on lrast_pkg, lrast_ctrl, lrast_dp and assert_macros.svh.
//
// Usage:
//   Input channel: a line request (x_start, y_start, x_end, y_end) is taken
//   when in_valid_i is high and in_stall_o is low. in_stall_o stays high
//   from the capture until the end point of that line has been taken.
//   Output channel: one item per pixel, start point first, taken when
//   out_valid_o is high and out_stall_i is low. last_pixel_o marks the end
//   point; equal endpoints give a single item with last_pixel_o set.
//   Timing: capture, then setup, then one pixel per cycle along the major
//   axis while out_stall_i is low. The first pixel is offered once the
//   setup state has passed.
//   Stall: while out_stall_i is high the current pixel holds and nothing
//   advances. Reset (rst_ni low, asynchronous) returns the controller to
//   idle, drops any line in progress and leaves the input open.
//   Coordinate bits above COORD_BITS are ignored, so points wrap.
module line_rasterizer_all_octants #(
  parameter int unsigned COORD_BITS = lrast_pkg::CoordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lrast_pkg::PixW-1:0] x_start_i,
  input  logic [lrast_pkg::PixW-1:0] y_start_i,
  input  logic [lrast_pkg::PixW-1:0] x_end_i,
  input  logic [lrast_pkg::PixW-1:0] y_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lrast_pkg::PixW-1:0] pixel_x_o,
  output logic [lrast_pkg::PixW-1:0] pixel_y_o,
  output logic                       last_pixel_o
);
  import lrast_pkg::*;

  lrast_cmd_t cmd;
  lrast_sts_t sts;

  // Sequence capture, setup and per-pixel advance.
  lrast_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the current pixel, decision term and remaining pixel count.
  lrast_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .pixel_x_o (pixel_x_o),
    .pixel_y_o (pixel_y_o)
  );

  // The end point is flagged from the remaining count.
  assign last_pixel_o = sts.last;

endmodule
